// File: rtl/chunk_fragment_deframer_macros.svh
// Assertion macros for the chunk fragment deframer.
// Included by the RTL files that carry concurrent assertions.
`ifndef CHUNK_FRAGMENT_DEFRAMER_MACROS_SVH
`define CHUNK_FRAGMENT_DEFRAMER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CFD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cfd_pkg.sv
// Package for the chunk fragment deframer: constants, codes and types.
// No dependencies; used by every module of the block.
`default_nettype none

package cfd_pkg;

    localparam int MAX_BLOCK_SIZE = 1048576;
    localparam int MIN_BLOCK_SIZE = 2;
    localparam int DEFAULT_BLOCK  = 32 * 1024;

    localparam int CFG_W  = 21;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int OFS_W  = $clog2(MAX_BLOCK_SIZE);
    localparam int SZ_W   = (CFG_W > OFS_W + 1) ? CFG_W : OFS_W + 1;
    localparam int LEN_W  = 6;
    localparam int FRAG_W = 18;
    localparam int CMP_W  = (OFS_W > FRAG_W) ? OFS_W : FRAG_W;

    localparam int RESET_SIZE = (DEFAULT_BLOCK > MAX_BLOCK_SIZE) ?
                                MAX_BLOCK_SIZE : DEFAULT_BLOCK;

    localparam logic [BYTE_W-1:0] HDR_EOS = 8'hC0;
    localparam logic [BYTE_W-1:0] HDR_EOC = 8'h80;
    localparam int BIG_SHIFT  = 6;
    localparam int HUGE_SHIFT = 12;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_CHUNK_END = 2'd1,
        KIND_EOS       = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_ENDED   = 2'd2,
        MODE_ERROR   = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload;
        logic              chunk_end;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/chunk_fragment_deframer.sv
// Top level of the chunk fragment deframer.
// Depends on cfd_pkg, cfd_front, cfd_fifo and cfd_back.
//
// Input channel s_*: one stream byte per request (valid/ready).
// Output channel m_*: zero or one result per byte: kind, payload, chunk_end.
// cfg_we/cfg_wdata write the block size; write only while the block is idle.
// Sizes below 2 act as 2, above MAX_BLOCK_SIZE as MAX_BLOCK_SIZE.
// Throughput: one byte per cycle while s_ready is high; the front end
// updates its block and fragment state in the cycle a byte is taken.
// A result is written into the queue at the edge that accepts its byte and
// moves into the output register on m_* once that register is empty or read.
// Fragment headers and padding produce no result; EOS, EOC and bad headers do.
// Reset: block offset 0, expecting a header, block size 32768, queue empty.
// When the receiver stalls, the output register holds one result and the
// 2-entry queue two more; s_ready then drops, and bytes that produce no
// result also wait for a free slot.
// End of stream and format error are sticky until reset.
`default_nettype none

module chunk_fragment_deframer (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire  [cfd_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [cfd_pkg::BYTE_W-1:0]   s_stream_byte,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [cfd_pkg::KIND_W-1:0]   m_kind,
    output logic [cfd_pkg::BYTE_W-1:0]   m_payload,
    output logic                         m_chunk_end
);
    import cfd_pkg::*;

    logic accept;
    logic push;
    res_t push_data;
    logic full;
    logic pop;
    logic rd_valid;
    res_t rd_data;

    assign s_ready = !full;
    assign accept  = s_valid && !full;

    cfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .stream_byte (s_stream_byte),
        .push        (push),
        .push_data   (push_data)
    );

    cfd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data)
    );

    cfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_valid    (rd_valid),
        .rd_data     (rd_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_payload   (m_payload),
        .m_chunk_end (m_chunk_end)
    );

endmodule

`default_nettype wire

// File: rtl/cfd_front.sv
// Front end: accepts stream bytes, tracks block and fragment state, classifies.
// Depends on cfd_pkg; pushes result requests into cfd_fifo.
`default_nettype none
`include "chunk_fragment_deframer_macros.svh"

module cfd_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire  [cfd_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire                          accept,
    input  wire  [cfd_pkg::BYTE_W-1:0]   stream_byte,
    output logic                         push,
    output cfd_pkg::res_t                push_data
);
    import cfd_pkg::*;

    logic [OFS_W-1:0]  size_m1_reg,   size_m1_next;
    logic [OFS_W-1:0]  offset_reg,    offset_next;
    logic [FRAG_W-1:0] frag_left_reg, frag_left_next;
    logic              runs_reg,      runs_next;
    logic              last_reg,      last_next;
    mode_t             mode_reg,      mode_next;

    logic [SZ_W-1:0]   cfg_wide;
    logic [SZ_W-1:0]   cfg_eff;
    logic              at_last;
    logic [OFS_W-1:0]  room;
    logic [LEN_W-1:0]  len6;
    logic [FRAG_W-1:0] len;
    logic              done;

    always_comb begin
        cfg_wide = SZ_W'(cfg_wdata);
        if (cfg_wide < SZ_W'(MIN_BLOCK_SIZE)) begin
            cfg_eff = SZ_W'(MIN_BLOCK_SIZE);
        end else if (cfg_wide > SZ_W'(MAX_BLOCK_SIZE)) begin
            cfg_eff = SZ_W'(MAX_BLOCK_SIZE);
        end else begin
            cfg_eff = cfg_wide;
        end
        size_m1_next = cfg_we ? OFS_W'(cfg_eff - SZ_W'(1)) : size_m1_reg;
    end

    always_comb begin
        at_last = (offset_reg >= size_m1_reg);
        room    = size_m1_reg - offset_reg;
        len6    = stream_byte[LEN_W-1:0];
        if (stream_byte[7]) begin
            len = stream_byte[6] ? (FRAG_W'(len6) << HUGE_SHIFT)
                                 : (FRAG_W'(len6) << BIG_SHIFT);
        end else begin
            len = FRAG_W'(len6);
        end
        done = runs_reg ? at_last : (frag_left_reg <= FRAG_W'(1));

        offset_next    = offset_reg;
        frag_left_next = frag_left_reg;
        runs_next      = runs_reg;
        last_next      = last_reg;
        mode_next      = mode_reg;
        push           = 1'b0;
        push_data      = '{kind: KIND_PAYLOAD, payload: '0, chunk_end: 1'b0};

        if (accept) begin
            offset_next = at_last ? '0 : offset_reg + OFS_W'(1);
            unique case (mode_reg)
                MODE_HEADER: begin
                    if (!at_last) begin
                        priority if (stream_byte == HDR_EOS) begin
                            push           = 1'b1;
                            push_data.kind = KIND_EOS;
                            mode_next      = MODE_ENDED;
                        end else if (stream_byte == HDR_EOC) begin
                            push           = 1'b1;
                            push_data.kind = KIND_CHUNK_END;
                            last_next      = 1'b1;
                        end else if (len6 == '0) begin
                            runs_next      = 1'b1;
                            frag_left_next = '0;
                            last_next      = stream_byte[6];
                            mode_next      = MODE_PAYLOAD;
                        end else if (CMP_W'(len) > CMP_W'(room)) begin
                            push           = 1'b1;
                            push_data.kind = KIND_ERROR;
                            mode_next      = MODE_ERROR;
                        end else begin
                            runs_next      = 1'b0;
                            frag_left_next = len;
                            last_next      = stream_byte[6] & ~stream_byte[7];
                            mode_next      = MODE_PAYLOAD;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    push                = 1'b1;
                    push_data.payload   = stream_byte;
                    push_data.chunk_end = done & last_reg;
                    if (!runs_reg && frag_left_reg != '0) begin
                        frag_left_next = frag_left_reg - FRAG_W'(1);
                    end
                    if (done) begin
                        mode_next      = MODE_HEADER;
                        runs_next      = 1'b0;
                        frag_left_next = '0;
                    end
                end
                MODE_ENDED: begin
                end
                MODE_ERROR: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_m1_reg   <= OFS_W'(RESET_SIZE - 1);
            offset_reg    <= '0;
            frag_left_reg <= '0;
            runs_reg      <= 1'b0;
            last_reg      <= 1'b0;
            mode_reg      <= MODE_HEADER;
        end else begin
            size_m1_reg   <= size_m1_next;
            offset_reg    <= offset_next;
            frag_left_reg <= frag_left_next;
            runs_reg      <= runs_next;
            last_reg      <= last_next;
            mode_reg      <= mode_next;
        end
    end

    `CFD_ASSERT(a_no_push_after_stop, aclk, aresetn,
        !((mode_reg == MODE_ENDED || mode_reg == MODE_ERROR) && push),
        "request pushed after end of stream or error")
    `CFD_ASSERT_NEXT(a_stop_sticky, aclk, aresetn,
        (mode_reg == MODE_ENDED || mode_reg == MODE_ERROR), $stable(mode_reg),
        "terminal mode left without reset")
    `CFD_ASSERT(a_offset_in_block, aclk, aresetn,
        !(mode_reg == MODE_PAYLOAD && !runs_reg && frag_left_reg == '0),
        "fixed-length fragment with no bytes left still in payload mode")

endmodule

`default_nettype wire

// File: rtl/cfd_fifo.sv
// Short request queue between the front end and the output stage.
// Depends on cfd_pkg for the request type and depth.
`default_nettype none
`include "chunk_fragment_deframer_macros.svh"

module cfd_fifo (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           push,
    input  cfd_pkg::res_t push_data,
    output logic          full,
    input  wire           pop,
    output logic          rd_valid,
    output cfd_pkg::res_t rd_data
);
    import cfd_pkg::*;

    res_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb begin
        full     = (count_reg == CNT_W'(FIFO_DEPTH));
        rd_valid = (count_reg != '0);
        rd_data  = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CFD_ASSERT(a_no_overflow, aclk, aresetn, !(push && full && !pop),
        "request pushed into full queue")
    `CFD_ASSERT(a_no_underflow, aclk, aresetn, !(pop && !rd_valid),
        "request popped from empty queue")
    `CFD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(FIFO_DEPTH),
        "queue count past depth")

endmodule

`default_nettype wire

// File: rtl/cfd_back.sv
// Output stage: pulls requests from the queue into the result register.
// Depends on cfd_pkg for the request type.
`default_nettype none

module cfd_back (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          rd_valid,
    input  cfd_pkg::res_t                rd_data,
    output logic                         pop,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [cfd_pkg::KIND_W-1:0]   m_kind,
    output logic [cfd_pkg::BYTE_W-1:0]   m_payload,
    output logic                         m_chunk_end
);
    import cfd_pkg::*;

    logic valid_reg, valid_next;
    res_t out_reg;

    always_comb begin
        pop        = rd_valid && (!valid_reg || m_ready);
        valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_payload   = out_reg.payload;
    assign m_chunk_end = out_reg.chunk_end;

endmodule

`default_nettype wire

// File: tb/tb_chunk_fragment_deframer.sv
// Self-checking testbench for chunk_fragment_deframer: directed and random byte streams.
// Predicts results with its own deframer state and checks them as they arrive.
// Depends on cfd_pkg and the chunk_fragment_deframer RTL.
`timescale 1ns / 100ps

module tb_chunk_fragment_deframer;
    import cfd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 40;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_stream_byte = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [KIND_W-1:0]   m_kind;
    logic [BYTE_W-1:0]   m_payload;
    logic                m_chunk_end;

    // deframer state as seen by the predictor
    logic [CFG_W-1:0]    blk_size_reg  = CFG_W'(DEFAULT_BLOCK);
    int unsigned         blk_ofs       = 0;
    int unsigned         frag_left     = 0;
    bit                  to_block_end  = 1'b0;
    bit                  chunk_last    = 1'b0;
    mode_t               rd_mode       = MODE_HEADER;
    res_t                expected_q[$];

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int                  hold_left     = 0;
    int                  stall_cycles  = 0;
    int                  n_mismatch    = 0;

    chunk_fragment_deframer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_payload     (m_payload),
        .m_chunk_end   (m_chunk_end)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned eff_size();
        int unsigned s;
        s = blk_size_reg;
        if (s < MIN_BLOCK_SIZE) s = MIN_BLOCK_SIZE;
        if (s > MAX_BLOCK_SIZE) s = MAX_BLOCK_SIZE;
        return s;
    endfunction

    function automatic void expect_result(kind_t k, logic [7:0] p, logic ce);
        res_t r;
        r.kind      = k;
        r.payload   = p;
        r.chunk_end = ce;
        expected_q.push_back(r);
    endfunction

    // advance the predicted deframer by one accepted byte
    function automatic void deframe_byte(logic [7:0] b);
        int unsigned size, room, len;
        bit at_last, last, done;
        size    = eff_size();
        at_last = (blk_ofs >= size - 1);
        case (rd_mode)
            MODE_HEADER: begin
                if (!at_last) begin
                    if (b == HDR_EOS) begin
                        expect_result(KIND_EOS, 8'h00, 1'b0);
                        rd_mode = MODE_ENDED;
                    end else if (b == HDR_EOC) begin
                        expect_result(KIND_CHUNK_END, 8'h00, 1'b0);
                        chunk_last = 1'b1;
                    end else begin
                        len  = b[5:0];
                        last = b[6];
                        if (len == 0) begin
                            to_block_end = 1'b1;
                            frag_left    = 0;
                            chunk_last   = last;
                            rd_mode      = MODE_PAYLOAD;
                        end else begin
                            room = size - 1 - blk_ofs;
                            if (b[7]) begin
                                last = 1'b0;
                                len  = len << (b[6] ? HUGE_SHIFT : BIG_SHIFT);
                            end
                            if (len > room) begin
                                expect_result(KIND_ERROR, 8'h00, 1'b0);
                                rd_mode = MODE_ERROR;
                            end else begin
                                to_block_end = 1'b0;
                                frag_left    = len;
                                chunk_last   = last;
                                rd_mode      = MODE_PAYLOAD;
                            end
                        end
                    end
                end
            end
            MODE_PAYLOAD: begin
                if (to_block_end) begin
                    done = at_last;
                end else begin
                    done = (frag_left <= 1);
                    if (frag_left > 0) frag_left--;
                end
                expect_result(KIND_PAYLOAD, b, done && chunk_last);
                if (done) begin
                    rd_mode      = MODE_HEADER;
                    to_block_end = 1'b0;
                    frag_left    = 0;
                end
            end
            default: ;
        endcase
        blk_ofs = at_last ? 0 : blk_ofs + 1;
    endfunction

    // well-formed next byte: headers always fit their block, payload is random
    function automatic logic [7:0] next_frame_byte();
        int unsigned size, room, pick, top;
        logic [7:0] b;
        size = eff_size();
        b    = 8'($urandom_range(0, 255));
        if (rd_mode != MODE_HEADER || blk_ofs >= size - 1) return b;
        room = size - 1 - blk_ofs;
        pick = $urandom_range(0, 99);
        if (pick < 8) return HDR_EOC;
        if (pick < 20 && room <= 300) return {1'b0, b[6], 6'd0};
        if (pick < 30 && room >= 64) begin
            top = room >> BIG_SHIFT;
            if (top > 8) top = 8;
            return {2'b10, 6'($urandom_range(1, top))};
        end
        top = (room > 63) ? 63 : room;
        return {1'b0, b[6], 6'($urandom_range(1, top))};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_mismatch < MAX_REPORTS)
            $display("%0t: %s mismatch, got %0h, want %0h", $realtime, what, got, want);
        n_mismatch++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
    endtask

    // no request offered until every pending result is out
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_blk_size(input logic [CFG_W-1:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        blk_size_reg  = value;
    endtask

    task automatic align_to_block_start();
        while (!(rd_mode == MODE_HEADER && blk_ofs == 0))
            send_byte(next_frame_byte());
    endtask

    function automatic logic [CFG_W-1:0] pick_blk_size();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'($urandom_range(200, 400));
            3:       return CFG_W'($urandom_range(2, 4));
            default: return CFG_W'($urandom_range(5, 80));
        endcase
    endfunction

    // reset block size, chunk end marker, plain and last fragments, field extremes
    task automatic test_directed_headers();
        send_byte(HDR_EOC);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'h41);
        send_byte(8'hA5);
        send_byte(8'h02);
        send_byte(8'hC3);
    endtask

    // size change mid-fragment and past the block end, padding headers, size clamp
    task automatic test_blk_size_changes();
        set_blk_size(CFG_W'(4));
        send_byte(8'h3C);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h01);
        send_byte(8'h44);
        send_byte(8'h41);
        send_byte(8'h55);
        send_byte(8'h02);
        send_byte(8'h66);
        send_byte(8'h77);
        send_byte(HDR_EOS);
        set_blk_size('0);
        send_byte(HDR_EOC);
        send_byte(HDR_EOC);
        send_byte(8'h40);
        send_byte(8'h88);
    endtask

    task automatic test_random_stream(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int count);
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) set_blk_size(pick_blk_size());
            send_byte(next_frame_byte());
        end
    endtask

    // receiver holds off while requests keep coming, then the queue drains
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_blk_size(CFG_W'(64));
        hold_left = 300;
        repeat (40) send_byte(next_frame_byte());
        wait_quiet();
    endtask

    // big fragment in a clamped maximum block
    task automatic test_long_fragments();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        while (rd_mode != MODE_HEADER) send_byte(next_frame_byte());
        set_blk_size({CFG_W{1'b1}});
        send_byte({2'b10, 6'($urandom_range(1, 4))});
        while (rd_mode == MODE_PAYLOAD) send_byte(8'($urandom_range(0, 255)));
        send_byte(next_frame_byte());
    endtask

    // end of stream or overrun, huge length against a room just under 4096;
    // both outcomes are sticky, so only one per run
    task automatic test_stream_termination();
        logic [7:0] hdr;
        send_idle_pct = 25;
        recv_idle_pct = 25;
        set_blk_size(CFG_W'(8));
        align_to_block_start();
        case ($urandom_range(0, 3))
            0:       hdr = HDR_EOS;
            1:       hdr = {1'b0, 1'($urandom_range(0, 1)), 6'($urandom_range(8, 63))};
            2:       hdr = {2'b10, 6'($urandom_range(1, 63))};
            default: begin
                set_blk_size(CFG_W'(4097));
                send_byte(8'h01);
                send_byte(8'($urandom_range(0, 255)));
                hdr = {2'b11, 6'd1};
            end
        endcase
        send_byte(hdr);
        send_byte(HDR_EOS);
        send_byte(HDR_EOC);
        send_byte(8'h01);
        repeat (10) send_byte(8'($urandom_range(0, 255)));
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unrequested result kind", m_kind, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_kind !== want.kind) report_mismatch("kind", m_kind, want.kind);
                if (m_payload !== want.payload)
                    report_mismatch("payload", m_payload, want.payload);
                if (m_chunk_end !== want.chunk_end)
                    report_mismatch("chunk_end", m_chunk_end, want.chunk_end);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_headers();
        test_blk_size_changes();
        test_random_stream(35, 79, 500);
        test_backpressure_fill();
        test_random_stream(79, 35, 500);
        test_long_fragments();
        test_random_stream(0, 0, 500);
        test_stream_termination();
        wait_quiet();
        if (n_mismatch == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_front.sv
rtl/cfd_fifo.sv
rtl/cfd_back.sv
rtl/chunk_fragment_deframer.sv
tb/tb_chunk_fragment_deframer.sv
